@@ hw/rtl/dlfr_pkg.sv @@
// ----------------------------------------------------------------------------
// dlfr_pkg: shared types and constants of the display link frame receiver
// Sizes, link state and status codes, and the structs between the modules.
// ----------------------------------------------------------------------------
package dlfr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int STACK_DEPTH = 5;
    localparam int FRAME_BYTES = 6;
    localparam int KEPT_BYTES  = FRAME_BYTES - 1;
    localparam int QUEUE_LIMIT = QUEUE_DEPTH - 2;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int SPTR_W = $clog2(STACK_DEPTH);
    localparam int BCNT_W = $clog2(FRAME_BYTES);

    localparam logic [7:0] ACK_RESET    = 8'd6;
    localparam logic [7:0] NAK_RESET    = 8'd21;
    localparam logic [7:0] REPORT_RESET = 8'd5;
    localparam logic [7:0] EVENT_RESET  = 8'd7;

    typedef enum logic [2:0] {
        LS_IDLE        = 3'd0,
        LS_WAIT_ACK    = 3'd1,
        LS_WAIT_REPORT = 3'd2,
        LS_RX_REPORT   = 3'd3,
        LS_RX_EVENT    = 3'd4
    } link_state_t;

    typedef enum logic [3:0] {
        ST_TAKEN      = 4'd0,
        ST_IGNORED    = 4'd1,
        ST_ACK        = 4'd2,
        ST_NAK        = 4'd3,
        ST_QUEUED     = 4'd4,
        ST_BAD_SUM    = 4'd5,
        ST_QUEUE_FULL = 4'd6,
        ST_NOTED      = 4'd7,
        ST_DEQUEUED   = 4'd8,
        ST_EMPTY      = 4'd9,
        ST_STACK_FULL = 4'd10
    } status_t;

    typedef enum logic [1:0] {
        REQ_BYTE    = 2'd0,
        REQ_WRITE   = 2'd1,
        REQ_READ    = 2'd2,
        REQ_DEQUEUE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_ACK    = 2'd0,
        CFG_NAK    = 2'd1,
        CFG_REPORT = 2'd2,
        CFG_EVENT  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] ack_code;
        logic [7:0] nak_code;
        logic [7:0] report_code;
        logic [7:0] event_code;
    } cfg_t;

    // byte i of a stored frame sits in element i
    typedef logic [KEPT_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic   load;   // a beat is processed this cycle
        logic   enq;
        logic   deq;
        frame_t frame;
    } q_cmd_t;

    typedef struct packed {
        logic              room;
        logic              not_empty;
        logic [QPTR_W-1:0] level;
    } q_stat_t;

endpackage

@@ hw/rtl/dlfr_frame_queue.sv @@
// ----------------------------------------------------------------------------
// dlfr_frame_queue: ring queue of received frames
// Frame memory with write/read pointers and a fill count; registered read.
// ----------------------------------------------------------------------------
module dlfr_frame_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dlfr_pkg::q_cmd_t             cmd,
    output dlfr_pkg::q_stat_t            stat,
    output dlfr_pkg::frame_t             rd_frame,
    output logic [dlfr_pkg::QPTR_W-1:0]  level
);
    import dlfr_pkg::*;

    frame_t            mem [QUEUE_DEPTH];
    frame_t            rd_frame_reg;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] total_reg, total_next;
    logic [QPTR_W-1:0] level_reg;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        total_next  = total_reg;
        if (cmd.enq)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
            total_next  = total_reg + 1'b1;
        end
        else if (cmd.deq)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
            total_next  = total_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            total_reg  <= '0;
            level_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            total_reg  <= total_next;
            if (cmd.load)
                level_reg <= total_next;
        end
    end

    // frame fields read as zero on any beat that is not a dequeue
    always_ff @(posedge clk)
    begin
        if (cmd.enq)
            mem[wr_ptr_reg] <= cmd.frame;
        if (cmd.load)
            rd_frame_reg <= cmd.deq ? mem[rd_ptr_reg] : '0;
    end

    assign stat.room      = (total_reg < QPTR_W'(QUEUE_LIMIT));
    assign stat.not_empty = (total_reg != '0);
    assign stat.level     = total_reg;
    assign rd_frame       = rd_frame_reg;
    assign level          = level_reg;

endmodule

@@ hw/rtl/dlfr_link_ctrl.sv @@
// ----------------------------------------------------------------------------
// dlfr_link_ctrl: link state stack and frame assembly
// Decodes one request per cycle while go is high, tracks the state stack, builds frames.
// ----------------------------------------------------------------------------
module dlfr_link_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  dlfr_pkg::req_t        req,
    input  logic [7:0]            rx_byte,
    input  dlfr_pkg::cfg_t        cfg,
    input  dlfr_pkg::q_stat_t     q_stat,
    output dlfr_pkg::q_cmd_t      q_cmd,
    output dlfr_pkg::status_t     status,
    output dlfr_pkg::link_state_t link_state
);
    import dlfr_pkg::*;

    link_state_t       stack_reg [STACK_DEPTH];
    link_state_t       stack_next [STACK_DEPTH];
    logic [SPTR_W-1:0] top_reg, top_next;
    logic [BCNT_W-1:0] bc_reg, bc_next, bc_eff;
    logic [7:0]        xor_reg, xor_next, xor_acc;
    frame_t            part_reg, part_next;

    link_state_t cur;
    link_state_t push_val;
    logic        full;
    logic        push_req, do_push, pop_req, replace, acc, enq, deq;

    assign cur  = stack_reg[top_reg];
    assign full = (top_reg == SPTR_W'(STACK_DEPTH - 1));

    // request decode
    always_comb
    begin
        push_req = 1'b0;
        push_val = LS_IDLE;
        pop_req  = 1'b0;
        replace  = 1'b0;
        acc      = 1'b0;
        deq      = 1'b0;
        status   = ST_IGNORED;
        unique case (req)
            REQ_BYTE:
            begin
                case (cur) inside
                    LS_IDLE:
                        if (rx_byte == cfg.event_code)
                        begin
                            push_req = 1'b1;
                            push_val = LS_RX_EVENT;
                        end
                    LS_WAIT_ACK:
                        if (rx_byte == cfg.ack_code)
                        begin
                            pop_req = 1'b1;
                            status  = ST_ACK;
                        end
                        else if (rx_byte == cfg.nak_code)
                        begin
                            pop_req = 1'b1;
                            status  = ST_NAK;
                        end
                        else if (rx_byte == cfg.event_code)
                        begin
                            push_req = 1'b1;
                            push_val = LS_RX_EVENT;
                        end
                    LS_WAIT_REPORT:
                        if (rx_byte == cfg.event_code)
                        begin
                            push_req = 1'b1;
                            push_val = LS_RX_EVENT;
                        end
                        else if (rx_byte == cfg.report_code)
                        begin
                            replace = 1'b1;
                            acc     = 1'b1;
                        end
                    LS_RX_REPORT, LS_RX_EVENT:
                        acc = 1'b1;
                    default: ;
                endcase
            end
            REQ_WRITE:
            begin
                push_req = 1'b1;
                push_val = LS_WAIT_ACK;
            end
            REQ_READ:
            begin
                push_req = 1'b1;
                push_val = LS_WAIT_REPORT;
            end
            REQ_DEQUEUE:
            begin
                deq    = q_stat.not_empty;
                status = q_stat.not_empty ? ST_DEQUEUED : ST_EMPTY;
            end
        endcase

        do_push = push_req && !full;
        if (push_req)
        begin
            if (full)
                status = ST_STACK_FULL;
            else if (req == REQ_BYTE)
                acc = 1'b1;
            else
                status = ST_NOTED;
        end

        // frame assembly and stack update
        bc_next    = bc_reg;
        xor_next   = xor_reg;
        part_next  = part_reg;
        top_next   = top_reg;
        stack_next = stack_reg;
        enq        = 1'b0;

        // a fresh receive state starts counting at zero
        bc_eff  = ((do_push && req == REQ_BYTE) || replace) ? '0 : bc_reg;
        xor_acc = (bc_eff == '0) ? rx_byte : (xor_reg ^ rx_byte);

        if (acc)
        begin
            xor_next = xor_acc;
            if (bc_eff < BCNT_W'(KEPT_BYTES))
                part_next[bc_eff] = rx_byte;
            if (bc_eff == BCNT_W'(FRAME_BYTES - 1))
            begin
                bc_next = '0;
                pop_req = 1'b1;
                if (xor_acc != 8'd0)
                    status = ST_BAD_SUM;
                else if (q_stat.room)
                begin
                    enq    = 1'b1;
                    status = ST_QUEUED;
                end
                else
                    status = ST_QUEUE_FULL;
            end
            else
            begin
                bc_next = bc_eff + 1'b1;
                status  = ST_TAKEN;
            end
        end

        if (do_push)
        begin
            top_next = top_reg + 1'b1;
            stack_next[top_reg + SPTR_W'(1)] = push_val;
        end
        if (replace)
            stack_next[top_reg] = LS_RX_REPORT;
        if (pop_req && top_reg != '0)
            top_next = top_reg - 1'b1;
    end

    assign link_state = stack_next[top_next];

    assign q_cmd.load  = go;
    assign q_cmd.enq   = go && enq;
    assign q_cmd.deq   = go && deq;
    assign q_cmd.frame = part_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            bc_reg  <= '0;
            xor_reg <= '0;
            for (int i = 0; i < STACK_DEPTH; i++)
                stack_reg[i] <= LS_IDLE;
        end
        else if (go)
        begin
            top_reg   <= top_next;
            bc_reg    <= bc_next;
            xor_reg   <= xor_next;
            stack_reg <= stack_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
            part_reg <= part_next;
    end

endmodule

@@ hw/rtl/display_link_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// display_link_frame_receiver: receive side of a serial display link
// Link state stack, frame checksum and a ring queue of good frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one beat is a request, req_type plus
//   rx_byte - a received byte, a write or read command note, or a dequeue.
//   Output channel (out_valid/out_stall): exactly one result beat per input
//   beat, in order: status, top link state, queue fill and, on a dequeue,
//   the frame fields (zero otherwise).
//   A beat accepted into the input register goes through the decode and
//   state update and is written into the result register, which raises
//   out_valid, once that register is empty or out_stall is low. Throughput
//   is one beat per clock while out_stall is low; the state stack, frame
//   assembler and queue pointers all update in the cycle a beat advances.
//   The input register still takes a beat while a result waits; in_stall
//   rises only when both the input and the result register are occupied and
//   out_stall is high.
//   Reset (rst_n low, async) empties the queue and the stack, leaves the link
//   idle and loads the default ack/nak/report/event codes. The cfg port
//   writes one code register per cycle with cfg_we; write only when idle.
// ----------------------------------------------------------------------------
module display_link_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [2:0]  link_state,
    output logic [3:0]  queue_level,
    output logic [7:0]  frame_command,
    output logic [7:0]  frame_object,
    output logic [7:0]  frame_index,
    output logic [15:0] frame_value,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import dlfr_pkg::*;

    // code registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_code    <= ACK_RESET;
            cfg_reg.nak_code    <= NAK_RESET;
            cfg_reg.report_code <= REPORT_RESET;
            cfg_reg.event_code  <= EVENT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ACK:    cfg_reg.ack_code    <= cfg_data;
                CFG_NAK:    cfg_reg.nak_code    <= cfg_data;
                CFG_REPORT: cfg_reg.report_code <= cfg_data;
                CFG_EVENT:  cfg_reg.event_code  <= cfg_data;
            endcase
        end
    end

    // input register; adv moves its beat through the update into the result
    logic       in_valid_reg;
    req_t       req_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    logic       adv;
    logic       in_take;

    assign adv      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !adv;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (adv)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg  <= req_t'(req_type);
            byte_reg <= rx_byte;
        end
    end

    // decode, stack and frame assembly
    q_cmd_t            q_cmd;
    q_stat_t           q_stat;
    status_t           status_comb;
    link_state_t       lstate_comb;
    frame_t            rd_frame;
    logic [QPTR_W-1:0] q_level;

    dlfr_link_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (adv),
        .req        (req_reg),
        .rx_byte    (byte_reg),
        .cfg        (cfg_reg),
        .q_stat     (q_stat),
        .q_cmd      (q_cmd),
        .status     (status_comb),
        .link_state (lstate_comb)
    );

    // frame queue; its read data and fill count register alongside the result
    dlfr_frame_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (q_cmd),
        .stat     (q_stat),
        .rd_frame (rd_frame),
        .level    (q_level)
    );

    // result register
    status_t     status_reg;
    link_state_t lstate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= ST_TAKEN;
            lstate_reg    <= LS_IDLE;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
            status_reg    <= status_comb;
            lstate_reg    <= lstate_comb;
        end
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign link_state    = lstate_reg;
    assign queue_level   = 4'(q_level);
    assign frame_command = rd_frame[0];
    assign frame_object  = rd_frame[1];
    assign frame_index   = rd_frame[2];
    assign frame_value   = {rd_frame[3], rd_frame[4]};

`ifndef SYNTHESIS
    // queue never holds more than its limit
    a_queue_limit: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.level <= QPTR_W'(QUEUE_LIMIT))
        else $error("frame queue over limit");

    // a dequeue removes exactly one frame
    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && q_cmd.deq) |=> (q_stat.level == $past(q_stat.level) - 1'b1))
        else $error("dequeue did not drop fill count by one");

    // frame fields are zero on every result that is not a dequeue
    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_DEQUEUED) |-> (rd_frame == '0))
        else $error("frame fields set on a non-dequeue result");
`endif

endmodule
